// ===== design/gauss_seidel_solver_assert.svh =====
// ----------------------------------------------------------------------------
// gauss_seidel_solver assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAUSS_SEIDEL_SOLVER_ASSERT_SVH
`define GAUSS_SEIDEL_SOLVER_ASSERT_SVH

// same-cycle implication
`define GSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg
// Types, codes and constants shared by the Gauss-Seidel solver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gss_pkg;

	localparam int EQUATIONS_DEF = 4;
	localparam int IDX_W         = 3;   // index width for up to eight unknowns
	localparam int ACC_W         = 52;  // numerator accumulator width
	localparam int SWEEP_LIMIT_RST = 5;
	localparam int TOLERANCE_RST   = 1;

	localparam logic [1:0] CMD_COEFF = 2'd0;
	localparam logic [1:0] CMD_RHS   = 2'd1;
	localparam logic [1:0] CMD_SOLVE = 2'd2;

	localparam logic [1:0] STS_CONVERGED = 2'd0;
	localparam logic [1:0] STS_LIMIT     = 2'd1;
	localparam logic [1:0] STS_ZERO_DIAG = 2'd2;

	localparam logic REG_SWEEP_LIMIT = 1'b0;
	localparam logic REG_TOLERANCE   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ROW,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_WAIT,
		ST_SWEEP,
		ST_EMIT
	} gss_state_t;

	typedef struct packed {
		logic             clear;
		logic             row_init;
		logic             mul;
		logic             acc;
		logic             div_start;
		logic             write;
		logic             emit;
		logic             last;
		logic [IDX_W-1:0] idx_i;
		logic [IDX_W-1:0] idx_j;
		logic [1:0]       status;
		logic [7:0]       sweeps;
	} gss_cmd_t;

	typedef struct packed {
		logic diag_zero;
		logic div_done;
		logic close;
		logic out_free;
	} gss_sts_t;

endpackage

// ===== design/gss_divider.sv =====
// ----------------------------------------------------------------------------
// gss_divider
// Iterative Q16.16 divider, one quotient bit per cycle, truncating toward
// zero with saturation to the 32-bit signed range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gss_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [gss_pkg::ACC_W-1:0] num,
	input  logic signed [31:0]              den,
	output logic                            done,
	output logic signed [31:0]              quo
);

	localparam int HI_W = gss_pkg::ACC_W - 16;

	logic                  busy_q;
	logic                  done_q;
	logic [4:0]            cnt_q;
	logic [31:0]           rem_q;
	logic [31:0]           dvd_q;
	logic [31:0]           quo_q;
	logic [31:0]           den_q;
	logic                  neg_q;
	logic                  sat_q;

	logic [gss_pkg::ACC_W-1:0] n_abs;
	logic [31:0]               d_abs;
	logic [HI_W-1:0]           hi;
	logic [32:0]               trial;
	logic [32:0]               diff;

	assign n_abs = num[gss_pkg::ACC_W-1] ? $unsigned(-num) : $unsigned(num);
	assign d_abs = den[31] ? $unsigned(-den) : $unsigned(den);
	assign hi    = n_abs[gss_pkg::ACC_W-1:16];
	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (hi >= HI_W'(d_abs)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= hi >= HI_W'(d_abs);
			neg_q <= num[gss_pkg::ACC_W-1] != den[31];
			den_q <= d_abs;
			rem_q <= hi[31:0];
			dvd_q <= {n_abs[15:0], 16'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (sat_q) begin
			quo = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (neg_q) begin
			quo = (quo_q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-quo_q);
		end else begin
			quo = quo_q[31] ? 32'sh7fff_ffff : $signed(quo_q);
		end
	end

	assign done = done_q;

endmodule

// ===== design/gss_datapath.sv =====
// ----------------------------------------------------------------------------
// gss_datapath
// Coefficient and right-hand-side stores, estimate registers, multiply and
// accumulate stage, divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gss_datapath #(
	parameter int EQUATIONS = gss_pkg::EQUATIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [1:0]          command,
	input  logic [1:0]          row,
	input  logic [1:0]          col,
	input  logic signed [31:0]  value,
	input  logic [15:0]         tolerance,
	input  gss_pkg::gss_cmd_t   cmd,
	output gss_pkg::gss_sts_t   sts,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [1:0]          index,
	output logic signed [31:0]  solution,
	output logic [1:0]          status,
	output logic [7:0]          sweeps_used,
	output logic                last
);

	localparam int IW = $clog2(EQUATIONS);
	localparam int AW = $clog2(EQUATIONS * EQUATIONS);

	logic signed [31:0] coeff_q [EQUATIONS*EQUATIONS];
	logic signed [31:0] rhs_q   [EQUATIONS];
	logic signed [31:0] cur_q   [EQUATIONS];

	logic signed [gss_pkg::ACC_W-1:0] acc_q;
	logic signed [31:0]               old_q;
	logic signed [63:0]               prod_s1;
	logic                             en_s1;
	logic                             out_valid_q;

	logic [IW-1:0]      ii;
	logic [IW-1:0]      jj;
	logic [IW-1:0]      sel;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] coeff_rd;
	logic signed [31:0] cur_rd;
	logic               div_done;
	logic signed [31:0] div_quo;
	logic signed [32:0] dlt;
	logic [32:0]        dlt_abs;

	assign ii       = cmd.idx_i[IW-1:0];
	assign jj       = cmd.idx_j[IW-1:0];
	assign sel      = cmd.mul ? jj : ii;
	assign rd_addr  = AW'(int'(ii) * EQUATIONS + int'(sel));
	assign wr_addr  = AW'(int'(row) * EQUATIONS + int'(col));
	assign coeff_rd = coeff_q[rd_addr];
	assign cur_rd   = cur_q[sel];

	assign dlt     = 33'(div_quo) - 33'(old_q);
	assign dlt_abs = dlt[32] ? $unsigned(-dlt) : $unsigned(dlt);

	assign sts.diag_zero = coeff_rd == 32'sd0;
	assign sts.div_done  = div_done;
	assign sts.close     = dlt_abs < {17'd0, tolerance};
	assign sts.out_free  = !out_valid_q || !out_stall;

	gss_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (acc_q),
		.den    (coeff_rd),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (load && command == gss_pkg::CMD_COEFF && int'(row) < EQUATIONS
				&& int'(col) < EQUATIONS) begin
			coeff_q[wr_addr] <= value;
		end
		if (load && command == gss_pkg::CMD_RHS && int'(row) < EQUATIONS) begin
			rhs_q[IW'(row)] <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < EQUATIONS; k++) begin
				cur_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				for (int k = 0; k < EQUATIONS; k++) begin
					cur_q[k] <= '0;
				end
			end else if (cmd.write) begin
				cur_q[ii] <= div_quo;
			end
			if (cmd.emit && sts.out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_init) begin
			acc_q <= gss_pkg::ACC_W'(rhs_q[ii]);
			old_q <= cur_rd;
		end else if (cmd.acc && en_s1) begin
			acc_q <= acc_q - gss_pkg::ACC_W'(prod_s1 >>> 16);
		end
		prod_s1 <= coeff_rd * cur_rd;
		en_s1   <= cmd.mul && (jj != ii);
		if (cmd.emit && sts.out_free) begin
			index       <= 2'(ii);
			solution    <= cur_rd;
			status      <= cmd.status;
			sweeps_used <= cmd.sweeps;
			last        <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/gss_ctrl.sv =====
// ----------------------------------------------------------------------------
// gss_ctrl
// Solve sequencer: diagonal check, row and term walk, divider handoff,
// sweep bookkeeping and result burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gauss_seidel_solver_assert.svh"

module gss_ctrl #(
	parameter int EQUATIONS = gss_pkg::EQUATIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [7:0]        sweep_limit,
	input  gss_pkg::gss_sts_t sts,
	output gss_pkg::gss_cmd_t cmd,
	output logic              busy
);

	localparam int IW = $clog2(EQUATIONS);
	localparam logic [IW-1:0] LAST_IDX = IW'(EQUATIONS - 1);

	gss_pkg::gss_state_t state_q, state_d;
	logic [IW-1:0] i_q, i_d;
	logic [IW-1:0] j_q, j_d;
	logic [7:0]    sweeps_q, sweeps_d;
	logic [1:0]    status_q, status_d;
	logic          close_q, close_d;
	logic [7:0]    sweep_nxt;

	assign sweep_nxt = sweeps_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gss_pkg::ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			sweeps_q <= '0;
			status_q <= gss_pkg::STS_LIMIT;
			close_q  <= 1'b1;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			sweeps_q <= sweeps_d;
			status_q <= status_d;
			close_q  <= close_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		sweeps_d = sweeps_q;
		status_d = status_q;
		close_d  = close_q;
		cmd        = '0;
		cmd.idx_i  = gss_pkg::IDX_W'(i_q);
		cmd.idx_j  = gss_pkg::IDX_W'(j_q);
		cmd.status = status_q;
		cmd.sweeps = sweeps_q;
		cmd.last   = i_q == LAST_IDX;
		unique case (state_q)
			gss_pkg::ST_IDLE: begin
				if (start) begin
					cmd.clear = 1'b1;
					sweeps_d  = '0;
					i_d       = '0;
					state_d   = gss_pkg::ST_CHECK;
				end
			end
			gss_pkg::ST_CHECK: begin
				if (sts.diag_zero) begin
					status_d = gss_pkg::STS_ZERO_DIAG;
					i_d      = '0;
					state_d  = gss_pkg::ST_EMIT;
				end else if (i_q == LAST_IDX) begin
					i_d     = '0;
					close_d = 1'b1;
					if (sweep_limit == 8'd0) begin
						status_d = gss_pkg::STS_LIMIT;
						state_d  = gss_pkg::ST_EMIT;
					end else begin
						state_d = gss_pkg::ST_ROW;
					end
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			gss_pkg::ST_ROW: begin
				cmd.row_init = 1'b1;
				j_d          = '0;
				state_d      = gss_pkg::ST_MUL;
			end
			gss_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = gss_pkg::ST_ACC;
			end
			gss_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				if (j_q == LAST_IDX) begin
					state_d = gss_pkg::ST_DIV;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = gss_pkg::ST_MUL;
				end
			end
			gss_pkg::ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = gss_pkg::ST_WAIT;
			end
			gss_pkg::ST_WAIT: begin
				if (sts.div_done) begin
					cmd.write = 1'b1;
					close_d   = close_q && sts.close;
					if (i_q == LAST_IDX) begin
						state_d = gss_pkg::ST_SWEEP;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = gss_pkg::ST_ROW;
					end
				end
			end
			gss_pkg::ST_SWEEP: begin
				sweeps_d = sweep_nxt;
				i_d      = '0;
				if (close_q) begin
					status_d = gss_pkg::STS_CONVERGED;
					state_d  = gss_pkg::ST_EMIT;
				end else if (sweep_nxt >= sweep_limit) begin
					status_d = gss_pkg::STS_LIMIT;
					state_d  = gss_pkg::ST_EMIT;
				end else begin
					close_d = 1'b1;
					state_d = gss_pkg::ST_ROW;
				end
			end
			gss_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.out_free) begin
					if (i_q == LAST_IDX) begin
						i_d     = '0;
						state_d = gss_pkg::ST_IDLE;
					end else begin
						i_d = i_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = gss_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != gss_pkg::ST_IDLE;

	`GSS_ASSERT_NOW(a_done_in_wait, sts.div_done, state_q == gss_pkg::ST_WAIT, "divider done outside wait")
	`GSS_ASSERT_NEXT(a_div_to_wait, state_q == gss_pkg::ST_DIV, state_q == gss_pkg::ST_WAIT, "divide not awaited")
	`GSS_ASSERT_NOW(a_limit_count, cmd.emit && status_q == gss_pkg::STS_LIMIT, sweeps_q == sweep_limit, "limit status with wrong sweep count")
	`GSS_ASSERT_NOW(a_zero_diag_count, cmd.emit && status_q == gss_pkg::STS_ZERO_DIAG, sweeps_q == 8'd0, "zero diagonal after sweeps")

endmodule

// ===== design/gauss_seidel_solver.sv =====
// ----------------------------------------------------------------------------
// gauss_seidel_solver
// Fixed-point Gauss-Seidel solver: loads, solve sequencing, result burst.
// ----------------------------------------------------------------------------
// Loads of a coefficient or right-hand-side element are accepted while the
// solver is idle. A solve first checks the diagonal, then runs sweeps in
// which every row walks its terms through one 32x32 multiplier, a multiply
// state and an accumulate state per term, and then waits on the iterative
// divider, which yields one quotient bit per cycle. The result burst emits
// the components in index order and holds while the output side stalls.
// Inputs are held off from the solve until the burst has been handed to the
// output register.
`timescale 1ns / 1ps

module gauss_seidel_solver #(
	parameter int EQUATIONS = gss_pkg::EQUATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         index,
	output logic signed [31:0] solution,
	output logic [1:0]         status,
	output logic [7:0]         sweeps_used,
	output logic               last,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [7:0]        sweep_limit_q;
	logic [15:0]       tolerance_q;
	logic              accept;
	logic              busy;
	gss_pkg::gss_cmd_t cmd;
	gss_pkg::gss_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_limit_q <= 8'(gss_pkg::SWEEP_LIMIT_RST);
			tolerance_q   <= 16'(gss_pkg::TOLERANCE_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gss_pkg::REG_SWEEP_LIMIT: sweep_limit_q <= cfg_data[7:0];
				gss_pkg::REG_TOLERANCE:   tolerance_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	gss_ctrl #(
		.EQUATIONS (EQUATIONS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept && command == gss_pkg::CMD_SOLVE),
		.sweep_limit (sweep_limit_q),
		.sts         (sts),
		.cmd         (cmd),
		.busy        (busy)
	);

	gss_datapath #(
		.EQUATIONS (EQUATIONS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.command     (command),
		.row         (row),
		.col         (col),
		.value       (value),
		.tolerance   (tolerance_q),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.index       (index),
		.solution    (solution),
		.status      (status),
		.sweeps_used (sweeps_used),
		.last        (last)
	);

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// gauss_seidel_solver testbench
// Loads coefficient matrices and right-hand sides, issues solves under random
// idling and output stalls, and checks every emitted component against an
// in-bench fixed-point Gauss-Seidel predictor, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int          N         = 4;
	localparam logic [1:0]  CMD_SPARE = 2'd3;
	localparam int          WATCHDOG  = 200000;
	localparam int          SETTLE    = 8;
	localparam int          Q_ONE     = 65536;

	typedef struct {
		logic [1:0]         index;
		logic signed [31:0] solution;
		logic [1:0]         status;
		logic [7:0]         sweeps_used;
		logic               last;
	} component_t;

	logic               clk, arst_n;
	logic               in_valid, in_stall;
	logic [1:0]         command, row, col;
	logic signed [31:0] value;
	logic               out_valid, out_stall;
	logic [1:0]         index;
	logic signed [31:0] solution;
	logic [1:0]         status;
	logic [7:0]         sweeps_used;
	logic               last;
	logic               cfg_we, cfg_index;
	logic [15:0]        cfg_data;

	gauss_seidel_solver DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .row(row), .col(col), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.index(index), .solution(solution), .status(status),
		.sweeps_used(sweeps_used), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [31:0] coeff_mem [N*N];
	logic signed [31:0] rhs_mem [N];
	logic [7:0]         sweep_cap;
	logic [15:0]        tol;
	component_t         pending_components [$];

	int  mismatches;
	int  items_sent;
	int  solves_sent;
	int  components_seen;
	bit  in_idle_on;
	bit  out_idle_on;
	bit  hold_toggle;
	int  idle_cycles;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic logic signed [31:0] q16_quotient(longint num, logic signed [31:0] den);
		bit                neg;
		longint unsigned   n, d, q, r, mag;
		neg = (num < 0) != (den < 0);
		n = magnitude(num);
		d = magnitude(longint'(den));
		q = n / d;
		r = n % d;
		if (q >= 64'h20000)
			return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		mag = (q << 16) + (r << 16) / d;
		if (neg)
			return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(mag));
		return (mag > 64'h7fff_ffff) ? 32'sh7fff_ffff : mag[31:0];
	endfunction

	task automatic predict_solution();
		logic signed [31:0] est [N];
		logic signed [31:0] prev [N];
		logic [1:0]         st;
		int                 sweeps;
		longint             acc, diff;
		bit                 all_close;
		component_t         c;
		st = gss_pkg::STS_LIMIT;
		sweeps = 0;
		for (int i = 0; i < N; i++) begin
			est[i] = 0;
			prev[i] = 0;
			if (coeff_mem[i*N+i] == 0)
				st = gss_pkg::STS_ZERO_DIAG;
		end
		if (st != gss_pkg::STS_ZERO_DIAG) begin
			while (sweeps < sweep_cap) begin
				all_close = 1;
				for (int i = 0; i < N; i++) begin
					acc = longint'(rhs_mem[i]);
					for (int j = 0; j < N; j++)
						if (j != i)
							acc -= (longint'(coeff_mem[i*N+j]) * longint'(est[j])) >>> 16;
					est[i] = q16_quotient(acc, coeff_mem[i*N+i]);
				end
				sweeps++;
				for (int i = 0; i < N; i++) begin
					diff = longint'(est[i]) - longint'(prev[i]);
					if (diff < 0)
						diff = -diff;
					if (!(diff < longint'(tol)))
						all_close = 0;
					prev[i] = est[i];
				end
				if (all_close) begin
					st = gss_pkg::STS_CONVERGED;
					break;
				end
			end
		end
		for (int i = 0; i < N; i++) begin
			c.index = 2'(i);
			c.solution = (st == gss_pkg::STS_ZERO_DIAG) ? 32'sd0 : est[i];
			c.status = st;
			c.sweeps_used = 8'(sweeps);
			c.last = (i == N - 1);
			pending_components.push_back(c);
		end
	endtask

	task automatic apply_item(logic [1:0] cmd, logic [1:0] r, logic [1:0] c,
			logic signed [31:0] v);
		case (cmd)
			gss_pkg::CMD_COEFF: coeff_mem[r*N+c] = v;
			gss_pkg::CMD_RHS:   rhs_mem[r] = v;
			gss_pkg::CMD_SOLVE: begin
				predict_solution();
				solves_sent++;
			end
			default: ;
		endcase
	endtask

	// one input beat; valid stays high into the next beat when no gap is drawn
	task automatic send_item(logic [1:0] cmd, logic [1:0] r, logic [1:0] c,
			logic signed [31:0] v);
		int gap;
		gap = 0;
		if (in_idle_on)
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command <= cmd;
		row <= r;
		col <= c;
		value <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		apply_item(cmd, r, c, v);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_components.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic sel, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == gss_pkg::REG_SWEEP_LIMIT)
			sweep_cap = data[7:0];
		else
			tol = data;
	endtask

	function automatic logic signed [31:0] rand_signed(int span);
		return $signed($urandom_range(0, 2*span)) - span;
	endfunction

	// mode 0: diagonally dominant, 1: full-range noise, 2: one zero diagonal
	task automatic load_system(int mode);
		logic signed [31:0] v;
		int                 zero_row;
		zero_row = $urandom_range(0, N-1);
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c < N; c++) begin
				if (mode == 1)
					v = $urandom;
				else if (r == c)
					v = (mode == 2 && r == zero_row) ? 0 :
						($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(6*Q_ONE, 16*Q_ONE));
				else
					v = rand_signed(2*Q_ONE);
				send_item(gss_pkg::CMD_COEFF, 2'(r), 2'(c), v);
			end
			send_item(gss_pkg::CMD_RHS, 2'(r), 2'd0,
				(mode == 1) ? $signed($urandom) : rand_signed(64*Q_ONE));
		end
	endtask

	task automatic test_basic_solve();
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c < N; c++)
				send_item(gss_pkg::CMD_COEFF, 2'(r), 2'(c),
					(r == c) ? 4*Q_ONE : ((r + c) % 2 ? Q_ONE : -Q_ONE));
			send_item(gss_pkg::CMD_RHS, 2'(r), 2'd0, (r + 1) * Q_ONE);
		end
		send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		drain();
	endtask

	task automatic test_field_extremes();
		send_item(gss_pkg::CMD_COEFF, 0, 0, 32'sd1);
		send_item(gss_pkg::CMD_RHS, 0, 3, 32'sh7fff_ffff);
		send_item(gss_pkg::CMD_COEFF, 3, 0, 32'sh8000_0000);
		send_item(gss_pkg::CMD_RHS, 3, 0, 32'sh8000_0000);
		send_item(CMD_SPARE, 3, 3, 32'shffff_ffff);
		send_item(gss_pkg::CMD_SOLVE, 3, 3, 32'sh7fff_ffff);
		drain();
		send_item(gss_pkg::CMD_COEFF, 1, 1, 0);
		send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		send_item(gss_pkg::CMD_COEFF, 1, 1, 5*Q_ONE);
		send_item(CMD_SPARE, 0, 0, 0);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(gss_pkg::REG_SWEEP_LIMIT, 16'd0);
		send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		drain();
		write_reg(gss_pkg::REG_SWEEP_LIMIT, 16'd255);
		write_reg(gss_pkg::REG_TOLERANCE, 16'd0);
		send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		drain();
		write_reg(gss_pkg::REG_SWEEP_LIMIT, 16'd1);
		write_reg(gss_pkg::REG_TOLERANCE, 16'hffff);
		send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		drain();
		write_reg(gss_pkg::REG_SWEEP_LIMIT, 16'd40);
		write_reg(gss_pkg::REG_TOLERANCE, 16'hffff);
		send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		drain();
	endtask

	task automatic test_backpressure();
		write_reg(gss_pkg::REG_SWEEP_LIMIT, 16'd3);
		write_reg(gss_pkg::REG_TOLERANCE, 16'd16);
		hold_toggle = ~hold_toggle;
		repeat (4) send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		load_system(0);
		send_item(gss_pkg::CMD_SOLVE, 0, 0, 0);
		drain();
	endtask

	task automatic test_random_systems();
		int mode;
		in_idle_on = 1;
		out_idle_on = 1;
		while (items_sent < 270) begin
			write_reg(gss_pkg::REG_SWEEP_LIMIT, 16'(($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 255) : $urandom_range(1, 8)));
			write_reg(gss_pkg::REG_TOLERANCE, 16'(($urandom_range(0, 3) == 0) ?
				$urandom : $urandom_range(0, 64)));
			mode = $urandom_range(0, 9);
			load_system(mode < 7 ? 0 : (mode < 9 ? 1 : 2));
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 3) == 0)
					send_item($urandom_range(0, 1) ? CMD_SPARE : gss_pkg::CMD_RHS,
						2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
				send_item(gss_pkg::CMD_SOLVE, 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), $urandom);
			end
			if ($urandom_range(0, 3) == 0) begin
				in_idle_on = 0;
				out_idle_on = 0;
			end else begin
				in_idle_on = 1;
				out_idle_on = 1;
			end
			drain();
		end
	endtask

	// output stall: random stretches, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int  stretch;
		bit  seen_toggle;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stretch = 0;
			seen_toggle = 0;
		end else if (hold_toggle != seen_toggle) begin
			seen_toggle = hold_toggle;
			out_stall <= 1'b1;
			stretch = 3000;
		end else if (stretch > 0) begin
			stretch--;
		end else if (!out_idle_on) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= $urandom_range(0, 1);
			stretch = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		component_t want;
		if (arst_n && out_valid && !out_stall) begin
			components_seen++;
			if (pending_components.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat index=%0d solution=%0d", $time,
					index, solution);
			end else begin
				want = pending_components.pop_front();
				if (index !== want.index) begin
					mismatches++;
					$display("%0t: index expected %0d actual %0d", $time, want.index, index);
				end
				if (solution !== want.solution) begin
					mismatches++;
					$display("%0t: solution expected %0d actual %0d", $time,
						want.solution, solution);
				end
				if (status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				end
				if (sweeps_used !== want.sweeps_used) begin
					mismatches++;
					$display("%0t: sweeps_used expected %0d actual %0d", $time,
						want.sweeps_used, sweeps_used);
				end
				if (last !== want.last) begin
					mismatches++;
					$display("%0t: last expected %0d actual %0d", $time, want.last, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("gauss_seidel_solver test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = gss_pkg::CMD_COEFF;
		row = 0;
		col = 0;
		value = 0;
		cfg_we = 1'b0;
		cfg_index = gss_pkg::REG_SWEEP_LIMIT;
		cfg_data = 0;
		hold_toggle = 0;
		in_idle_on = 0;
		out_idle_on = 0;
		idle_cycles = 0;
		mismatches = 0;
		items_sent = 0;
		solves_sent = 0;
		components_seen = 0;
		sweep_cap = 8'(gss_pkg::SWEEP_LIMIT_RST);
		tol = 16'(gss_pkg::TOLERANCE_RST);
		for (int i = 0; i < N*N; i++)
			coeff_mem[i] = 0;
		for (int i = 0; i < N; i++)
			rhs_mem[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_solve();
		test_field_extremes();
		test_register_extremes();
		test_backpressure();
		test_random_systems();
		drain();

		$display("Covered %0d input beats, %0d solves, %0d result beats checked.",
			items_sent, solves_sent, components_seen);
		$display("Included zero diagonals, sweep limits 0..255, tolerance 0 and max, saturation.");
		if (mismatches == 0 && pending_components.size() == 0) begin
			$display("gauss_seidel_solver test passed");
		end else begin
			$display("gauss_seidel_solver test failed");
		end
		$finish;
	end

endmodule
